>>> src/i2cm_pkg.sv
// Shared types and constants for the I2C master register-access block.
`default_nettype none

package i2cm_pkg;

    // Request codes carried in the input item's req_type field
    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_READ  = 2'd2,
        REQ_LOAD  = 2'd3
    } req_t;

    // Which byte is on the wire
    typedef enum logic [1:0] {
        KIND_ADDR_W = 2'd0,
        KIND_REG    = 2'd1,
        KIND_DATA   = 2'd2,
        KIND_ADDR_R = 2'd3
    } kind_t;

    // Bus sequencer phases, one-hot
    typedef enum logic [14:0] {
        PH_IDLE      = 15'b000000000000001,
        PH_START_A   = 15'b000000000000010,
        PH_START_B   = 15'b000000000000100,
        PH_TX_LOW    = 15'b000000000001000,
        PH_TX_HIGH   = 15'b000000000010000,
        PH_ACK_LOW   = 15'b000000000100000,
        PH_ACK_HIGH  = 15'b000000001000000,
        PH_RS_LOW    = 15'b000000010000000,
        PH_RX_LOW    = 15'b000000100000000,
        PH_RX_HIGH   = 15'b000001000000000,
        PH_MACK_LOW  = 15'b000010000000000,
        PH_MACK_HIGH = 15'b000100000000000,
        PH_STOP_A    = 15'b001000000000000,
        PH_STOP_B    = 15'b010000000000000,
        PH_STOP_C    = 15'b100000000000000
    } phase_t;

    // Configuration register indexes
    localparam logic CFG_HALF_PERIOD = 1'b0;
    localparam logic CFG_ACK_TIMEOUT = 1'b1;

    localparam logic [7:0] HALF_PERIOD_RESET = 8'd2;
    localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;

    typedef struct packed {
        logic [7:0] half_period_ticks;
        logic [7:0] ack_timeout_polls;
    } cfg_t;

    typedef struct packed {
        req_t       req_type;
        logic [7:0] dev_addr;
        logic [7:0] reg_addr;
        logic [4:0] length;
        logic [3:0] byte_index;
        logic [7:0] write_byte;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic       rx_last;
        logic       busy_res;
        logic       done_res;
        logic       ack_error;
    } res_t;

endpackage

`default_nettype wire

>>> src/i2c_master_register_access_top.sv
// Top level of the I2C master register-access block: stream ports and config.
`default_nettype none

// One input transaction per clock: each item is a bus tick (with the sampled
// SDA level) or an idle-time command, and yields exactly one result item.
// The block sustains one item per cycle while results are taken; each
// item passes through the input register, the bus sequencer and the result
// register in that order. A stalled result output holds the
// input off once both registers are full. A begin command given while idle
// counts as the first start tick; commands given while busy act as plain
// ticks. Configuration writes are taken every cycle and should only be made
// while no transaction is in flight.
module i2c_master_register_access_top
    import i2cm_pkg::*;
#(
    parameter int MAX_LEN = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // dev_addr[7:0], reg_addr[15:8], length[20:16], byte_index[24:21],
    // write_byte[32:25], sda_in[33], zero[39:34]
    input  wire logic [39:0] s_tdata,
    // req_type[1:0]
    input  wire logic [1:0]  s_tuser,
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // scl_level[0], sda_level[1], sda_drive[2], rx_byte[10:3], rx_valid[11],
    // busy_res[12], done_res[13], ack_error[14], zero[15]
    output logic [15:0]      m_tdata,
    output logic             m_tlast,
    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data
);

    logic  in_valid_reg, in_valid_next;
    item_t in_item_reg;
    logic  out_valid_reg, out_valid_next;
    res_t  out_res_reg;
    cfg_t  cfg_reg;
    res_t  res;
    logic  s_accept, advance;

    // Pipeline handshake
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_item_reg.req_type   <= req_t'(s_tuser);
            in_item_reg.dev_addr   <= s_tdata[7:0];
            in_item_reg.reg_addr   <= s_tdata[15:8];
            in_item_reg.length     <= s_tdata[20:16];
            in_item_reg.byte_index <= s_tdata[24:21];
            in_item_reg.write_byte <= s_tdata[32:25];
            in_item_reg.sda_in     <= s_tdata[33];
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= res;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_period_ticks <= HALF_PERIOD_RESET;
            cfg_reg.ack_timeout_polls <= ACK_TIMEOUT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_HALF_PERIOD: cfg_reg.half_period_ticks <= cfg_data;
                CFG_ACK_TIMEOUT: cfg_reg.ack_timeout_polls <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    i2cm_engine #(
        .MAX_LEN(MAX_LEN)
    ) u_engine (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (advance),
        .item (in_item_reg),
        .cfg  (cfg_reg),
        .res  (res)
    );

    // Output packing
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_res_reg.rx_last;
    assign m_tdata  = {1'b0,
                       out_res_reg.ack_error,
                       out_res_reg.done_res,
                       out_res_reg.busy_res,
                       out_res_reg.rx_valid,
                       out_res_reg.rx_byte,
                       out_res_reg.sda_drive,
                       out_res_reg.sda_level,
                       out_res_reg.scl_level};

endmodule

`default_nettype wire

>>> src/i2cm_txbuf.sv
// Generic RAM with one write port and a registered read port.
`default_nettype none

module i2cm_txbuf #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port, out-of-range slots read as zero
    always_ff @(posedge clk)
    begin
        if (32'(raddr) < DEPTH)
        begin
            rdata_reg <= mem_reg[raddr];
        end
        else
        begin
            rdata_reg <= '0;
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> src/i2cm_engine.sv
// I2C bus sequencer: state registers and per-tick next-state logic.
`default_nettype none

module i2cm_engine
    import i2cm_pkg::*;
#(
    parameter int MAX_LEN = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  en,
    input  wire item_t item,
    input  wire cfg_t  cfg,
    output res_t       res
);

    localparam int AW      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LEN_SAT = (MAX_LEN > 31) ? 31 : MAX_LEN;

    phase_t     phase_reg, phase_next;
    kind_t      kind_reg, kind_next;
    logic       is_read_reg, is_read_next;
    logic [7:0] addr_hold_reg, addr_hold_next;
    logic [7:0] reg_hold_reg, reg_hold_next;
    logic [4:0] bytes_left_reg, bytes_left_next;
    logic [AW-1:0] byte_pos_reg, byte_pos_next;
    logic [2:0] bit_count_reg, bit_count_next;
    logic [7:0] shift_reg, shift_next;
    logic [8:0] tick_reg, tick_next;
    logic [7:0] poll_reg, poll_next;
    logic       err_reg, err_next;

    logic          buf_we;
    logic [AW-1:0] buf_waddr;
    logic [7:0]    buf_rdata;

    logic [7:0] half;
    logic [9:0] tick_inc;
    logic       hit_h, hit_2h;
    logic [8:0] tick_h, tick_2h;
    logic [4:0] len_sat;

    // Read data is registered, so it follows byte_pos in the cycle after; byte_pos
    // is steady for a whole byte time before the next data byte is fetched
    i2cm_txbuf #(
        .WIDTH(8),
        .DEPTH(MAX_LEN),
        .AW   (AW)
    ) u_txbuf (
        .clk  (clk),
        .we   (buf_we),
        .waddr(buf_waddr),
        .wdata(item.write_byte),
        .raddr(byte_pos_reg),
        .rdata(buf_rdata)
    );

    // Buffer load, only while the bus is idle
    always_comb
    begin
        buf_waddr = AW'(item.byte_index);
        buf_we    = en && (phase_reg == PH_IDLE) && (item.req_type == REQ_LOAD)
                    && (32'(item.byte_index) < MAX_LEN);
    end

    // Half period, zero counts as one tick
    assign half = (cfg.half_period_ticks == 8'd0) ? 8'd1 : cfg.half_period_ticks;

    always_comb
    begin
        if (32'(item.length) > MAX_LEN)
        begin
            len_sat = 5'(LEN_SAT);
        end
        else
        begin
            len_sat = item.length;
        end
    end

    // Next state and result for one tick
    always_comb
    begin
        phase_next      = phase_reg;
        kind_next       = kind_reg;
        is_read_next    = is_read_reg;
        addr_hold_next  = addr_hold_reg;
        reg_hold_next   = reg_hold_reg;
        bytes_left_next = bytes_left_reg;
        byte_pos_next   = byte_pos_reg;
        bit_count_next  = bit_count_reg;
        shift_next      = shift_reg;
        tick_next       = tick_reg;
        poll_next       = poll_reg;
        err_next        = err_reg;

        res = '0;
        res.scl_level = 1'b1;
        res.sda_level = 1'b1;

        // Begin command while idle; this tick is already the first start tick
        if (phase_reg == PH_IDLE && (item.req_type == REQ_WRITE ||
                                     item.req_type == REQ_READ))
        begin
            is_read_next    = (item.req_type == REQ_READ);
            addr_hold_next  = item.dev_addr;
            reg_hold_next   = item.reg_addr;
            bytes_left_next = len_sat;
            byte_pos_next   = '0;
            bit_count_next  = 3'd0;
            shift_next      = 8'd0;
            tick_next       = 9'd0;
            poll_next       = 8'd0;
            kind_next       = KIND_ADDR_W;
            err_next        = 1'b0;
            phase_next      = PH_START_A;
        end

        // Tick counter against one and two half periods
        tick_inc = {1'b0, tick_next} + 10'd1;
        hit_h    = tick_inc >= {2'b00, half};
        hit_2h   = tick_inc >= {1'b0, half, 1'b0};
        tick_h   = hit_h ? 9'd0 : tick_inc[8:0];
        tick_2h  = hit_2h ? 9'd0 : tick_inc[8:0];

        unique case (phase_next)
            PH_IDLE:
            begin
            end
            PH_START_A:
            begin
                res.sda_drive = 1'b1;
                tick_next     = tick_2h;
                if (hit_2h)
                begin
                    phase_next = PH_START_B;
                end
            end
            PH_START_B:
            begin
                res.sda_level = 1'b0;
                res.sda_drive = 1'b1;
                tick_next     = tick_2h;
                if (hit_2h)
                begin
                    if (kind_next == KIND_REG)
                    begin
                        kind_next  = KIND_ADDR_R;
                        shift_next = addr_hold_next | 8'h01;
                    end
                    else
                    begin
                        kind_next  = KIND_ADDR_W;
                        shift_next = addr_hold_next & 8'hFE;
                    end
                    bit_count_next = 3'd0;
                    phase_next     = PH_TX_LOW;
                end
            end
            PH_TX_LOW, PH_TX_HIGH:
            begin
                res.scl_level = (phase_next == PH_TX_HIGH);
                res.sda_level = shift_next[7];
                res.sda_drive = 1'b1;
                tick_next     = tick_h;
                if (hit_h)
                begin
                    if (phase_next == PH_TX_LOW)
                    begin
                        phase_next = PH_TX_HIGH;
                    end
                    else
                    begin
                        shift_next = {shift_next[6:0], 1'b0};
                        if (bit_count_next == 3'd7)
                        begin
                            bit_count_next = 3'd0;
                            phase_next     = PH_ACK_LOW;
                        end
                        else
                        begin
                            bit_count_next = bit_count_next + 3'd1;
                            phase_next     = PH_TX_LOW;
                        end
                    end
                end
            end
            PH_ACK_LOW:
            begin
                res.scl_level = 1'b0;
                tick_next     = tick_h;
                if (hit_h)
                begin
                    poll_next  = 8'd0;
                    phase_next = PH_ACK_HIGH;
                end
            end
            PH_ACK_HIGH:
            begin
                if (!item.sda_in)
                begin
                    // Acknowledged: pick the next byte or phase
                    poll_next = 8'd0;
                    tick_next = 9'd0;
                    case (kind_next)
                        KIND_ADDR_W:
                        begin
                            kind_next      = KIND_REG;
                            shift_next     = reg_hold_next;
                            bit_count_next = 3'd0;
                            phase_next     = PH_TX_LOW;
                        end
                        KIND_REG, KIND_DATA:
                        begin
                            if (kind_next == KIND_REG && is_read_next)
                            begin
                                phase_next = PH_RS_LOW;
                            end
                            else if (bytes_left_next == 5'd0)
                            begin
                                phase_next = PH_STOP_A;
                            end
                            else
                            begin
                                kind_next       = KIND_DATA;
                                shift_next      = buf_rdata;
                                byte_pos_next   = byte_pos_next + AW'(1);
                                bytes_left_next = bytes_left_next - 5'd1;
                                bit_count_next  = 3'd0;
                                phase_next      = PH_TX_LOW;
                            end
                        end
                        default:
                        begin
                            if (bytes_left_next == 5'd0)
                            begin
                                phase_next = PH_STOP_A;
                            end
                            else
                            begin
                                bit_count_next = 3'd0;
                                shift_next     = 8'd0;
                                phase_next     = PH_RX_LOW;
                            end
                        end
                    endcase
                end
                else if (poll_next >= cfg.ack_timeout_polls)
                begin
                    // Acknowledge timeout
                    poll_next  = 8'd0;
                    err_next   = 1'b1;
                    tick_next  = 9'd0;
                    phase_next = PH_STOP_A;
                end
                else
                begin
                    poll_next = poll_next + 8'd1;
                end
            end
            PH_RS_LOW:
            begin
                res.scl_level = 1'b0;
                res.sda_drive = 1'b1;
                tick_next     = tick_h;
                if (hit_h)
                begin
                    phase_next = PH_START_A;
                end
            end
            PH_RX_LOW:
            begin
                res.scl_level = 1'b0;
                tick_next     = tick_h;
                if (hit_h)
                begin
                    phase_next = PH_RX_HIGH;
                end
            end
            PH_RX_HIGH:
            begin
                tick_next = tick_h;
                if (hit_h)
                begin
                    shift_next = {shift_next[6:0], item.sda_in};
                    if (bit_count_next == 3'd7)
                    begin
                        bit_count_next = 3'd0;
                        res.rx_valid   = 1'b1;
                        res.rx_byte    = shift_next;
                        res.rx_last    = (bytes_left_next <= 5'd1);
                        if (bytes_left_next != 5'd0)
                        begin
                            bytes_left_next = bytes_left_next - 5'd1;
                        end
                        phase_next = PH_MACK_LOW;
                    end
                    else
                    begin
                        bit_count_next = bit_count_next + 3'd1;
                        phase_next     = PH_RX_LOW;
                    end
                end
            end
            PH_MACK_LOW, PH_MACK_HIGH:
            begin
                // ACK all bytes but the last, which gets a NACK
                res.scl_level = (phase_next == PH_MACK_HIGH);
                res.sda_level = (bytes_left_next == 5'd0);
                res.sda_drive = 1'b1;
                tick_next     = tick_h;
                if (hit_h)
                begin
                    if (phase_next == PH_MACK_LOW)
                    begin
                        phase_next = PH_MACK_HIGH;
                    end
                    else if (bytes_left_next == 5'd0)
                    begin
                        tick_next  = 9'd0;
                        phase_next = PH_STOP_A;
                    end
                    else
                    begin
                        shift_next = 8'd0;
                        phase_next = PH_RX_LOW;
                    end
                end
            end
            PH_STOP_A:
            begin
                res.scl_level = 1'b0;
                res.sda_level = 1'b0;
                res.sda_drive = 1'b1;
                tick_next     = tick_2h;
                if (hit_2h)
                begin
                    phase_next = PH_STOP_B;
                end
            end
            PH_STOP_B:
            begin
                res.sda_level = 1'b0;
                res.sda_drive = 1'b1;
                tick_next     = tick_2h;
                if (hit_2h)
                begin
                    phase_next = PH_STOP_C;
                end
            end
            PH_STOP_C:
            begin
                res.sda_drive = 1'b1;
                tick_next     = tick_2h;
                if (hit_2h)
                begin
                    res.done_res  = 1'b1;
                    res.ack_error = err_next;
                    err_next      = 1'b0;
                    phase_next    = PH_IDLE;
                end
            end
            default:
            begin
                tick_next  = 9'd0;
                phase_next = PH_IDLE;
            end
        endcase

        res.busy_res = (phase_next != PH_IDLE);
    end

    // State registers, advanced once per processed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            kind_reg       <= KIND_ADDR_W;
            is_read_reg    <= 1'b0;
            addr_hold_reg  <= 8'd0;
            reg_hold_reg   <= 8'd0;
            bytes_left_reg <= 5'd0;
            byte_pos_reg   <= '0;
            bit_count_reg  <= 3'd0;
            shift_reg      <= 8'd0;
            tick_reg       <= 9'd0;
            poll_reg       <= 8'd0;
            err_reg        <= 1'b0;
        end
        else if (en)
        begin
            phase_reg      <= phase_next;
            kind_reg       <= kind_next;
            is_read_reg    <= is_read_next;
            addr_hold_reg  <= addr_hold_next;
            reg_hold_reg   <= reg_hold_next;
            bytes_left_reg <= bytes_left_next;
            byte_pos_reg   <= byte_pos_next;
            bit_count_reg  <= bit_count_next;
            shift_reg      <= shift_next;
            tick_reg       <= tick_next;
            poll_reg       <= poll_next;
            err_reg        <= err_next;
        end
    end

endmodule

`default_nettype wire
